// ----- hdl/json_key_value_extract_assert.svh -----
`ifndef JSON_KEY_VALUE_EXTRACT_ASSERT_SVH
`define JSON_KEY_VALUE_EXTRACT_ASSERT_SVH

// Check that holds only while out of reset
`define JKV_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check in the next cycle, only while out of reset
`define JKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check in the next cycle, reset included
`define JKV_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/jkv_pkg.sv -----
package jkv_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int LENGTH_BITS   = 16;

    localparam int KEY_LEN_W = 5;
    localparam int KEY_BYTES = 16;
    localparam int KCNT_W    = $clog2(MAX_KEY_BYTES + 2);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CLOSE = 8'h7D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LENGTH     = 2'd0,
        CFG_KEY_BYTES_LOW  = 2'd1,
        CFG_KEY_BYTES_HIGH = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_VALUE     = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_DONE  = 4'd0,
        PH_SEEK  = 4'd1,
        PH_KEY   = 4'd2,
        PH_COLON = 4'd3,
        PH_TYPE  = 4'd4,
        PH_QVAL  = 4'd5,
        PH_BVAL  = 4'd6,
        PH_SKIP  = 4'd7
    } t_phase;

    typedef struct packed {
        logic [7:0] json_byte;
        logic       doc_start;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  value_byte;
        logic [15:0] value_length;
    } t_out;

    // Key settings handed from the register file to the parser
    typedef struct packed {
        logic [KEY_LEN_W-1:0]   key_length;
        logic [8*KEY_BYTES-1:0] key_bytes;
    } t_key_cfg;

endpackage

// ----- hdl/jkv_parser.sv -----
module jkv_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  jkv_pkg::t_in      i_item,
    input  jkv_pkg::t_key_cfg i_key_cfg,
    output logic              o_res_valid,
    output jkv_pkg::t_out     o_res
);
    import jkv_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [KCNT_W-1:0]      r_kcnt, n_kcnt;
    logic                   r_keq, n_keq;
    logic [LENGTH_BITS-1:0] r_vcnt, n_vcnt;

    logic       is_nul, is_quote, is_term;
    logic [7:0] kcnt_ext;
    logic [7:0] key_byte;
    logic [31:0] vcnt_ext;
    logic [15:0] found_len;

    // Classify the incoming byte
    assign is_nul   = (i_item.json_byte == CH_NUL);
    assign is_quote = (i_item.json_byte == CH_QUOTE);
    assign is_term  = (i_item.json_byte == CH_COMMA) || (i_item.json_byte == CH_CLOSE);

    // Pick the key byte at the current position
    assign kcnt_ext = 8'(r_kcnt);
    assign key_byte = i_key_cfg.key_bytes[8*kcnt_ext[3:0] +: 8];

    // Saturate the reported length to 16 bits
    assign vcnt_ext  = 32'(r_vcnt);
    assign found_len = (vcnt_ext > 32'h0000_FFFF) ? 16'hFFFF : vcnt_ext[15:0];

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_kcnt  <= '0;
            r_keq   <= 1'b1;
            r_vcnt  <= '0;
        end else begin
            r_phase <= n_phase;
            r_kcnt  <= n_kcnt;
            r_keq   <= n_keq;
            r_vcnt  <= n_vcnt;
        end
    end

    // Advance the parser one byte per accepted transaction
    always_comb begin
        n_phase     = r_phase;
        n_kcnt      = r_kcnt;
        n_keq       = r_keq;
        n_vcnt      = r_vcnt;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            priority if (i_item.doc_start) begin
                n_kcnt  = '0;
                n_keq   = 1'b1;
                n_vcnt  = '0;
                n_phase = PH_SEEK;
                if (is_nul) begin
                    n_phase           = PH_DONE;
                    o_res_valid       = 1'b1;
                    o_res.result_kind = KIND_NOT_FOUND;
                end
            end else if (r_phase == PH_DONE) begin
                n_phase = PH_DONE;
            end else if (is_nul) begin
                n_phase           = PH_DONE;
                o_res_valid       = 1'b1;
                o_res.result_kind = KIND_NOT_FOUND;
            end else begin
                unique case (r_phase)
                    PH_SEEK: begin
                        if (is_quote) begin
                            n_kcnt  = '0;
                            n_keq   = 1'b1;
                            n_phase = PH_KEY;
                        end
                    end
                    PH_KEY: begin
                        if (is_quote) begin
                            if (r_keq && kcnt_ext == 8'(i_key_cfg.key_length)) begin
                                n_phase = PH_COLON;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            if (kcnt_ext >= 8'(MAX_KEY_BYTES) || i_item.json_byte != key_byte) begin
                                n_keq = 1'b0;
                            end
                            if (kcnt_ext <= 8'(MAX_KEY_BYTES)) begin
                                n_kcnt = r_kcnt + 1'b1;
                            end
                        end
                    end
                    PH_COLON: begin
                        n_phase = PH_TYPE;
                    end
                    PH_TYPE: begin
                        n_vcnt = '0;
                        if (is_quote) begin
                            n_phase = PH_QVAL;
                        end else if (is_term) begin
                            n_phase           = PH_DONE;
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_FOUND;
                        end else begin
                            n_phase           = PH_BVAL;
                            n_vcnt            = LENGTH_BITS'(1);
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_VALUE;
                            o_res.value_byte  = i_item.json_byte;
                        end
                    end
                    PH_QVAL, PH_BVAL: begin
                        if ((r_phase == PH_QVAL) ? is_quote : is_term) begin
                            n_phase            = PH_DONE;
                            o_res_valid        = 1'b1;
                            o_res.result_kind  = KIND_FOUND;
                            o_res.value_length = found_len;
                        end else begin
                            if (r_vcnt != '1) begin
                                n_vcnt = r_vcnt + 1'b1;
                            end
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_VALUE;
                            o_res.value_byte  = i_item.json_byte;
                        end
                    end
                    PH_SKIP: begin
                        if (i_item.json_byte == CH_COMMA) begin
                            n_phase = PH_SEEK;
                        end else if (i_item.json_byte == CH_CLOSE) begin
                            n_phase           = PH_DONE;
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

endmodule

// ----- hdl/jkv_fifo.sv -----
module jkv_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  jkv_pkg::t_out i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_empty,
    output jkv_pkg::t_out o_rdata
);
    import jkv_pkg::*;

    t_out                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  do_wr, do_rd;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = do_wr ? FIFO_PTR_W'((32'(r_wr_ptr) + 1) % FIFO_DEPTH) : r_wr_ptr;
        n_rd_ptr = do_rd ? FIFO_PTR_W'((32'(r_rd_ptr) + 1) % FIFO_DEPTH) : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store a result
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ----- hdl/json_key_value_extract.sv -----
// A result is written into the result queue at the clock edge that accepts its byte.
// One byte is accepted per cycle while full is low; the parser updates its phase once per byte.
// A four-entry result queue lets input continue while results wait to be popped;
// full rises only when that queue holds four unread results.
// Reset (synchronous, active low) clears the queue and leaves the parser waiting for a
// document start; the key registers reset to zero.
module json_key_value_extract (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  jkv_pkg::t_in                        i_in,
    output logic                                empty,
    input  logic                                pop,
    output jkv_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jkv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [jkv_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import jkv_pkg::*;

    logic [KEY_LEN_W-1:0]  r_key_length;
    logic [CFG_DATA_W-1:0] r_key_low;
    logic [CFG_DATA_W-1:0] r_key_high;
    t_key_cfg              key_cfg;
    logic                  accept;
    logic                  res_valid;
    t_out                  res;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign key_cfg.key_length = r_key_length;
    assign key_cfg.key_bytes  = {r_key_high, r_key_low};

    // Write key registers on a configuration transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= '0;
            r_key_low    <= '0;
            r_key_high   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_LENGTH:     r_key_length <= i_cfg_data[KEY_LEN_W-1:0];
                CFG_KEY_BYTES_LOW:  r_key_low    <= i_cfg_data;
                CFG_KEY_BYTES_HIGH: r_key_high   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    jkv_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in),
        .i_key_cfg   (key_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jkv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res),
        .o_full  (full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (o_out)
    );

endmodule

// ----- hdl/jkv_checker.sv -----
`include "json_key_value_extract_assert.svh"

module jkv_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          push,
    input logic          full,
    input logic          empty,
    input jkv_pkg::t_out o_out
);
    import jkv_pkg::*;

    // Reset drains all pending results
    `JKV_ASSERT_RESET(a_reset_empty, !i_rst_n, empty, "queue not empty after reset")

    // Results only appear after an accepted byte
    `JKV_ASSERT_NEXT(a_no_spurious, empty && !(push && !full), empty, "result without input")

    // Result kind is always a legal code
    `JKV_ASSERT(a_kind_legal, !empty, (o_out.result_kind == KIND_VALUE) ||
        (o_out.result_kind == KIND_FOUND) || (o_out.result_kind == KIND_NOT_FOUND),
        "illegal result kind")

    // Only a found result carries a length
    `JKV_ASSERT(a_len_found, !empty && o_out.result_kind != KIND_FOUND,
        o_out.value_length == 16'd0, "length on non-found result")

endmodule

bind json_key_value_extract jkv_checker u_checker (.*);

// ----- verif/json_key_value_extract_checker.sv -----
module json_key_value_extract_checker
    import jkv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  t_in                   i_in,
    input  logic                  empty,
    input  logic                  pop,
    input  t_out                  i_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    // Key settings as last written
    logic [KEY_LEN_W-1:0] key_len;
    logic [63:0]          key_lo;
    logic [63:0]          key_hi;

    // Scanner state
    t_phase            phase;
    logic [KCNT_W-1:0] key_count;
    logic              key_equal;
    logic [15:0]       value_count;

    t_out pending_results[$];
    int   fails;

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Advance the scanner by one character; report the result it causes, if any
    task automatic scan_char(input t_in item, output bit produced, output t_out res);
        logic [7:0]   c;
        logic [127:0] key_all;
        c = item.json_byte;
        key_all = {key_hi, key_lo};
        produced = 1'b0;
        res = '0;
        if (item.doc_start) begin
            key_count = '0;
            key_equal = 1'b1;
            value_count = '0;
            phase = PH_SEEK;
            if (c == CH_NUL) begin
                phase = PH_DONE;
                produced = 1'b1;
                res.result_kind = KIND_NOT_FOUND;
            end
        end else if (phase == PH_DONE) begin
            produced = 1'b0;
        end else if (c == CH_NUL) begin
            phase = PH_DONE;
            produced = 1'b1;
            res.result_kind = KIND_NOT_FOUND;
        end else begin
            case (phase)
                PH_SEEK: begin
                    if (c == CH_QUOTE) begin
                        key_count = '0;
                        key_equal = 1'b1;
                        phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (c == CH_QUOTE) begin
                        phase = (key_equal && key_count == key_len) ? PH_COLON : PH_SKIP;
                    end else begin
                        if (key_count >= MAX_KEY_BYTES ||
                            c != key_all[8*key_count[3:0] +: 8]) begin
                            key_equal = 1'b0;
                        end
                        if (key_count <= MAX_KEY_BYTES) key_count++;
                    end
                end
                PH_COLON: begin
                    phase = PH_TYPE;
                end
                PH_TYPE, PH_QVAL, PH_BVAL: begin
                    if (phase == PH_TYPE) value_count = '0;
                    produced = !(phase == PH_TYPE && c == CH_QUOTE);
                    if ((phase == PH_QVAL && c == CH_QUOTE) ||
                        (phase != PH_QVAL && (c == CH_COMMA || c == CH_CLOSE))) begin
                        // Terminator: report the length and close the document
                        res.result_kind = KIND_FOUND;
                        res.value_length = value_count;
                        phase = PH_DONE;
                    end else if (phase == PH_TYPE && c == CH_QUOTE) begin
                        phase = PH_QVAL;
                    end else begin
                        if (value_count != 16'hFFFF) value_count++;
                        res.result_kind = KIND_VALUE;
                        res.value_byte = c;
                        if (phase == PH_TYPE) phase = PH_BVAL;
                    end
                end
                PH_SKIP: begin
                    if (c == CH_COMMA) begin
                        phase = PH_SEEK;
                    end else if (c == CH_CLOSE) begin
                        phase = PH_DONE;
                        produced = 1'b1;
                        res.result_kind = KIND_NOT_FOUND;
                    end
                end
                default: begin
                    phase = PH_DONE;
                end
            endcase
        end
    endtask

    // Track register writes, compare popped results, predict pushed characters
    always @(posedge i_clk) begin
        bit   produced;
        t_out res;
        t_out want;
        if (!i_rst_n) begin
            key_len = '0;
            key_lo = '0;
            key_hi = '0;
            phase = PH_DONE;
            key_count = '0;
            key_equal = 1'b1;
            value_count = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_LENGTH:     key_len = i_cfg_data[KEY_LEN_W-1:0];
                    CFG_KEY_BYTES_LOW:  key_lo = i_cfg_data;
                    CFG_KEY_BYTES_HIGH: key_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0d len %0d",
                             $time, i_out.result_kind, i_out.value_byte, i_out.value_length);
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", want.result_kind, i_out.result_kind);
                    check_field("value_byte", want.value_byte, i_out.value_byte);
                    check_field("value_length", want.value_length, i_out.value_length);
                end
            end
            if (push && !full) begin
                scan_char(i_in, produced, res);
                if (produced) pending_results.push_back(res);
            end
        end
        o_fail_count <= fails;
        o_outstanding <= pending_results.size();
    end

endmodule

// ----- verif/json_key_value_extract_tb.sv -----
module json_key_value_extract_tb;
    import jkv_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_ITEMS     = 1650;
    localparam int RANDOM_PHASES    = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in                   in_item;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out                  out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int outstanding;
    int cycles;

    // Stimulus state
    logic [7:0]           doc_q[$];
    logic [KEY_LEN_W-1:0] cur_len;
    logic [127:0]         cur_key;
    bit                   calm_push;
    bit                   pop_calm;
    int                   pop_stall;
    int                   sent_items;

    json_key_value_extract u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out       (out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    json_key_value_extract_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in          (in_item),
        .empty         (empty),
        .pop           (pop),
        .i_out         (out_item),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int push_gap();
        if (calm_push || $urandom_range(0, 99) < 60) return 0;
        return stall_len();
    endfunction

    function automatic logic [7:0] rand_char_except(input logic [7:0] a, input logic [7:0] b,
                                                     input logic [7:0] c);
        logic [7:0] ch;
        do ch = 8'($urandom_range(1, 255)); while (ch == a || ch == b || ch == c);
        return ch;
    endfunction

    function automatic logic [63:0] rand_key_word();
        logic [63:0] w;
        for (int i = 0; i < 8; i++) w[8*i +: 8] = rand_char_except(CH_QUOTE, CH_QUOTE, CH_QUOTE);
        return w;
    endfunction

    // Result side: random stalls with quiet stretches
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) pop_calm = !pop_calm;
        if (pop_stall > 0) begin
            pop = 1'b0;
            pop_stall--;
        end else begin
            pop = 1'b1;
            if (!pop_calm && $urandom_range(0, 99) < 20) pop_stall = stall_len();
        end
    end

    // Offer one character and hold it until a transaction takes it; called at a falling edge
    task automatic push_char(input logic [7:0] ch, input logic start);
        int gap;
        gap = push_gap();
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        in_item.json_byte = ch;
        in_item.doc_start = start;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_doc();
        foreach (doc_q[i]) push_char(doc_q[i], i == 0);
        sent_items += doc_q.size();
        doc_q.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
    endtask

    // Drain every expected result, then let the pipeline settle
    task automatic wait_idle();
        push = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_key(input logic [KEY_LEN_W-1:0] len, input logic [63:0] lo,
                            input logic [63:0] hi);
        wait_idle();
        cfg_write(CFG_KEY_LENGTH, CFG_DATA_W'(len));
        cfg_write(CFG_KEY_BYTES_LOW, lo);
        cfg_write(CFG_KEY_BYTES_HIGH, hi);
        cur_len = len;
        cur_key = {hi, lo};
    endtask

    // Key text: exact, prefix, extended, one character altered, or unrelated
    task automatic add_key();
        int sel;
        int n;
        int altered;
        logic [7:0] ch;
        sel = $urandom_range(0, 9);
        n = cur_len;
        altered = -1;
        if (sel == 4 && n > 0) n--;
        if (sel == 5) n++;
        if (sel == 6 && n > 0) altered = $urandom_range(0, n - 1);
        if (sel >= 7) n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            ch = (sel < 7 && i < cur_len && i < KEY_BYTES) ? cur_key[8*i +: 8]
                                                          : rand_char_except(CH_QUOTE, 8'h00,
                                                                             8'h00);
            if (i == altered) ch = rand_char_except(CH_QUOTE, ch, ch);
            doc_q.push_back(ch);
        end
    endtask

    task automatic add_value();
        int sel;
        int n;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            n = $urandom_range(0, 10);
            doc_q.push_back(CH_QUOTE);
            repeat (n) doc_q.push_back(rand_char_except(CH_QUOTE, CH_QUOTE, CH_QUOTE));
            doc_q.push_back(CH_QUOTE);
        end else begin
            n = (sel == 9) ? 0 : $urandom_range(1, 8);
            repeat (n) doc_q.push_back(rand_char_except(CH_QUOTE, CH_COMMA, CH_CLOSE));
        end
    endtask

    task automatic build_doc();
        int pairs;
        pairs = $urandom_range(1, 4);
        doc_q.push_back("{");
        if ($urandom_range(0, 9) == 0) doc_q.push_back(CH_CLOSE);
        for (int k = 0; k < pairs; k++) begin
            if (k > 0) doc_q.push_back(CH_COMMA);
            doc_q.push_back(CH_QUOTE);
            add_key();
            doc_q.push_back(CH_QUOTE);
            doc_q.push_back(($urandom_range(0, 9) == 0) ? rand_char_except(8'h00, 8'h00, 8'h00)
                                                        : ":");
            add_value();
        end
        doc_q.push_back(CH_CLOSE);
    endtask

    // Mostly well-formed documents, mixed with broken ones and raw noise
    task automatic run_random(input int target);
        int first;
        int sel;
        int n;
        first = sent_items;
        while (sent_items - first < target) begin
            if ($urandom_range(0, 99) < 15) calm_push = !calm_push;
            sel = $urandom_range(0, 99);
            build_doc();
            if (sel >= 65 && sel < 85) begin
                // Cut short, maybe with a NUL, else the next start abandons it
                n = $urandom_range(1, doc_q.size());
                while (doc_q.size() > n) void'(doc_q.pop_back());
                if ($urandom_range(0, 1)) doc_q.push_back(CH_NUL);
            end
            if (sel >= 85) begin
                doc_q.delete();
                n = $urandom_range(1, 12);
                repeat (n) push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                sent_items += n;
            end else begin
                send_doc();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        calm_push = 1'b0;
        sent_items = 0;
        cur_len = '0;
        cur_key = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: key "id", byte 0 in the low bits
        load_key(5'd2, 64'h6469, 64'h0);
        doc_q.push_back(CH_NUL);
        send_doc();
        add_text("{}");
        doc_q.push_back(CH_NUL);
        send_doc();
        add_text("{\"x\":1}");
        send_doc();
        add_text("{\"id\":\"a\"}");
        send_doc();
        add_text("{\"id\":}");
        send_doc();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: load_key(5'd0, {$urandom, $urandom}, {$urandom, $urandom});
                1: load_key(5'd16, rand_key_word(), rand_key_word());
                2: load_key(5'd1, rand_key_word(), 64'h0);
                3: load_key(5'd31, '1, '1);
                4: load_key(5'($urandom_range(0, 31)), {$urandom, $urandom},
                            {$urandom, $urandom});
                default: load_key(5'($urandom_range(1, 15)), rand_key_word(), rand_key_word());
            endcase
            run_random(RANDOM_ITEMS / RANDOM_PHASES);
        end

        wait_idle();
        if (fail_count == 0 && empty) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
